### hdl/hsvrgb_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB converter.
// No dependencies; imported by hsv_to_rgb_converter_unit.
`default_nettype none

package hsvrgb_pkg;

   // Hue scale: 1/16 degree units
   localparam logic [15:0] HUE_FULL_TURN = 16'd5760;
   localparam logic [12:0] HUE_SECTOR    = 13'd960;
   localparam int          HUE_W         = 13;
   localparam int          FRAC_W        = 10;

   // Common denominator for all channel terms: 255 * 960
   localparam int          DEN_W         = 18;
   localparam logic [DEN_W-1:0] SECTOR_DEN = 18'd244800;

   // Scaled numerator before rounding: v * (DEN - s * w), below 2^26
   localparam int          NUM_W         = 26;
   localparam logic [NUM_W-1:0] ROUND_HALF = 26'd122400;

   // Reciprocal of SECTOR_DEN: floor(2^26 / 244800); quotient is floor or floor - 1
   localparam int          RECIP_W       = 9;
   localparam int          RECIP_SHIFT   = 26;
   localparam logic [RECIP_W-1:0] RECIP  = 9'd274;
   localparam int          QUOT_W        = 9;

   localparam int          CHAN_W        = 8;
   localparam int          LANES         = 3;

   // Hue sector, 60 degrees each
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // Which term a channel shows
   typedef enum logic [1:0] {
      TERM_V,   // value itself, weight 0
      TERM_P,   // v(1-s), weight 960
      TERM_Q,   // v(1-s*f), weight r
      TERM_T    // v(1-s(1-f)), weight 960-r
   } term_type;

   // Lane index: 0 red, 1 green, 2 blue
   function automatic term_type term_for(input sector_type sector, input logic [1:0] lane);
      term_type term;
      term = TERM_V;
      case (sector)
         SECTOR_0: term = (lane == 2'd0) ? TERM_V : (lane == 2'd1) ? TERM_T : TERM_P;
         SECTOR_1: term = (lane == 2'd0) ? TERM_Q : (lane == 2'd1) ? TERM_V : TERM_P;
         SECTOR_2: term = (lane == 2'd0) ? TERM_P : (lane == 2'd1) ? TERM_V : TERM_T;
         SECTOR_3: term = (lane == 2'd0) ? TERM_P : (lane == 2'd1) ? TERM_Q : TERM_V;
         SECTOR_4: term = (lane == 2'd0) ? TERM_T : (lane == 2'd1) ? TERM_P : TERM_V;
         default:  term = (lane == 2'd0) ? TERM_V : (lane == 2'd1) ? TERM_P : TERM_Q;
      endcase
      return term;
   endfunction

   // First hue code of each sector
   function automatic logic [HUE_W-1:0] sector_base(input sector_type sector);
      logic [HUE_W-1:0] base;
      case (sector)
         SECTOR_0: base = 13'd0;
         SECTOR_1: base = 13'd960;
         SECTOR_2: base = 13'd1920;
         SECTOR_3: base = 13'd2880;
         SECTOR_4: base = 13'd3840;
         default:  base = 13'd4800;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

### hdl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter, five-stage pipeline with output register.
// Depends on hsvrgb_pkg for constants, sector/term types and lookup functions.
`default_nettype none

// One pixel beat per clock, sustained while rsp_tready is high. A beat accepted
// on req_ passes through the stage 1 to 4 registers and then the output register
// to rsp_. The pipeline has one stall enable: while the output register holds a
// beat that is not taken, every stage holds and req_tready is low, so throughput
// is set by the sink alone. Stages: full-turn hue check and sector split, weight
// select and s*w product, v*(den - s*w), reciprocal multiply for the divide by
// 244800, then remainder correction and saturation into the output register.
module hsv_to_rgb_converter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);
   import hsvrgb_pkg::*;

   logic advance;

   // stage 1: full-turn check and sector split
   logic                 s1_valid_ff,  s1_valid_in;
   sector_type           s1_sector_ff, s1_sector_in;
   logic [FRAC_W-1:0]    s1_frac_ff,   s1_frac_in;
   logic [CHAN_W-1:0]    s1_sat_ff,    s1_sat_in;
   logic [CHAN_W-1:0]    s1_bright_ff, s1_bright_in;

   // stage 2: s * weight per lane
   logic                 s2_valid_ff,  s2_valid_in;
   logic [DEN_W-1:0]     s2_prod_ff   [LANES];
   logic [DEN_W-1:0]     s2_prod_in   [LANES];
   logic [CHAN_W-1:0]    s2_bright_ff, s2_bright_in;

   // stage 3: scaled numerator
   logic                 s3_valid_ff,  s3_valid_in;
   logic [NUM_W-1:0]     s3_num_ff    [LANES];
   logic [NUM_W-1:0]     s3_num_in    [LANES];

   // stage 4: rounded numerator and estimated quotient
   logic                 s4_valid_ff,  s4_valid_in;
   logic [NUM_W-1:0]     s4_num_ff    [LANES];
   logic [NUM_W-1:0]     s4_num_in    [LANES];
   logic [QUOT_W-1:0]    s4_quot_ff   [LANES];
   logic [QUOT_W-1:0]    s4_quot_in   [LANES];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff,  rsp_data_in;

   logic [NUM_W:0]       s5_rem       [LANES];

   // whole pipe moves when the output register is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // stage 1 logic: hue at or above a full turn forced to 0, sector by threshold compares, offset in sector
   always_comb begin
      logic [HUE_W-1:0] hue_w;
      logic [HUE_W-1:0] offset;
      if (req_tdata[15:0] >= HUE_FULL_TURN) begin
         hue_w = '0;
      end else begin
         hue_w = req_tdata[HUE_W-1:0];
      end
      if (hue_w >= 13'd4800)      s1_sector_in = SECTOR_5;
      else if (hue_w >= 13'd3840) s1_sector_in = SECTOR_4;
      else if (hue_w >= 13'd2880) s1_sector_in = SECTOR_3;
      else if (hue_w >= 13'd1920) s1_sector_in = SECTOR_2;
      else if (hue_w >= 13'd960)  s1_sector_in = SECTOR_1;
      else                        s1_sector_in = SECTOR_0;
      offset       = hue_w - sector_base(s1_sector_in);
      s1_frac_in   = offset[FRAC_W-1:0];
      s1_sat_in    = req_tdata[23:16];
      s1_bright_in = req_tdata[31:24];
      s1_valid_in  = req_tvalid;
   end

   // stage 2 logic: pick each lane's weight and multiply by saturation
   always_comb begin
      logic [FRAC_W-1:0] weight;
      for (int lane = 0; lane < LANES; lane++) begin
         case (term_for(s1_sector_ff, 2'(lane)))
            TERM_V:  weight = '0;
            TERM_P:  weight = HUE_SECTOR[FRAC_W-1:0];
            TERM_Q:  weight = s1_frac_ff;
            TERM_T:  weight = HUE_SECTOR[FRAC_W-1:0] - s1_frac_ff;
            default: weight = '0;
         endcase
         s2_prod_in[lane] = DEN_W'(s1_sat_ff) * DEN_W'(weight);
      end
      s2_bright_in = s1_bright_ff;
      s2_valid_in  = s1_valid_ff;
   end

   // stage 3 logic: v * (den - s*w)
   always_comb begin
      logic [DEN_W-1:0] term;
      for (int lane = 0; lane < LANES; lane++) begin
         term            = SECTOR_DEN - s2_prod_ff[lane];
         s3_num_in[lane] = NUM_W'(s2_bright_ff) * NUM_W'(term);
      end
      s3_valid_in = s2_valid_ff;
   end

   // stage 4 logic: add half, estimate quotient by reciprocal multiply
   always_comb begin
      logic [NUM_W+RECIP_W-1:0] wide;
      for (int lane = 0; lane < LANES; lane++) begin
         s4_num_in[lane]  = s3_num_ff[lane] + ROUND_HALF;
         wide             = (NUM_W+RECIP_W)'(s4_num_in[lane]) * (NUM_W+RECIP_W)'(RECIP);
         s4_quot_in[lane] = wide[RECIP_SHIFT +: QUOT_W];
      end
      s4_valid_in = s3_valid_ff;
   end

   // stage 5 logic: correct estimate by one, saturate to 8 bits
   always_comb begin
      logic [NUM_W:0]    back;
      logic [QUOT_W-1:0] quot;
      rsp_data_in = '0;
      for (int lane = 0; lane < LANES; lane++) begin
         back         = (NUM_W+1)'(s4_quot_ff[lane]) * (NUM_W+1)'(SECTOR_DEN);
         s5_rem[lane] = (NUM_W+1)'(s4_num_ff[lane]) - back;
         quot         = s4_quot_ff[lane];
         if (s5_rem[lane] >= (NUM_W+1)'(SECTOR_DEN)) begin
            quot = quot + 1'b1;
         end
         if (quot > QUOT_W'(255)) begin
            rsp_data_in[lane*CHAN_W +: CHAN_W] = '1;
         end else begin
            rsp_data_in[lane*CHAN_W +: CHAN_W] = quot[CHAN_W-1:0];
         end
      end
      rsp_valid_in = s4_valid_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= s1_sat_in;
         s1_bright_ff <= s1_bright_in;
         s2_prod_ff   <= s2_prod_in;
         s2_bright_ff <= s2_bright_in;
         s3_num_ff    <= s3_num_in;
         s4_num_ff    <= s4_num_in;
         s4_quot_ff   <= s4_quot_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

`ifndef SYNTH
   // an accepted beat always lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat did not reach stage 1");

   // a held output freezes every stage's valid bit
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff}))
      else $error("pipeline moved during stall");

   // reciprocal estimate is never more than one below the true quotient
   a_recip_bound_0: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s5_rem[0] < (NUM_W+1)'(2 * 244800))
      else $error("red quotient estimate out of range");

   a_recip_bound_1: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s5_rem[1] < (NUM_W+1)'(2 * 244800))
      else $error("green quotient estimate out of range");

   a_recip_bound_2: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s5_rem[2] < (NUM_W+1)'(2 * 244800))
      else $error("blue quotient estimate out of range");
`endif

endmodule

`default_nettype wire
